// ===== design/fed_pkg.sv =====
// Shared constants for the feedback echo delay: register map, field widths
// and the fixed-point rounding constants. No dependencies.
`default_nettype none

package fed_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int DELAY_W = 17;
    localparam int GAIN_W  = 16;
    localparam int LEVEL_W = 17;

    localparam int Q_FRAC     = 16;
    localparam int ROUND_HALF = 32768;

    typedef logic [2:0] reg_index_t;

    localparam reg_index_t REG_DELAY_LENGTH  = 3'd0;
    localparam reg_index_t REG_FEEDBACK_GAIN = 3'd1;
    localparam reg_index_t REG_TONE_COEFF    = 3'd2;
    localparam reg_index_t REG_MIX_LEVEL     = 3'd3;
    localparam reg_index_t REG_EFFECT_EN     = 3'd4;

    localparam logic [DELAY_W-1:0] DELAY_LENGTH_RST  = 17'd16800;
    localparam logic [GAIN_W-1:0]  FEEDBACK_GAIN_RST = 16'd26214;
    localparam logic [GAIN_W-1:0]  TONE_COEFF_RST    = 16'd45547;
    localparam logic [LEVEL_W-1:0] MIX_LEVEL_RST     = 17'd32768;

endpackage

`default_nettype wire

// ===== design/fed_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module fed_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 131072,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/feedback_echo_delay.sv =====
// Feedback echo delay with a one-pole lowpass in the feedback path.
// Depends on fed_pkg and fed_ram.
//
// Channel   Direction  Transaction contents
// s_axis    in         tdata: in_sample (SAMPLE_BITS, signed), zero padded
// m_axis    out        tdata: out_sample (SAMPLE_BITS, signed), zero padded
// APB       in/out     five registers at byte addresses 0, 4, 8, 12, 16
//
// An enabled sample passes through S_READ, S_TONE, S_MIX, S_FDBK, S_WRITE and
// S_DONE: one delay memory read, three passes through the shared multiplier,
// and the memory write, then the load of the output register. A bypassed
// sample goes from acceptance straight to S_DONE. The input is accepted only
// while the sequencer is idle; S_DONE stalls until the output is free; a
// finished result waits in the output register, and a new sample may enter
// meanwhile. Reset clears the write index and the filter state and loads the
// register defaults at once. Memory entries not yet written since reset read
// as zero, tracked by the write index and a wrap flag, so no clearing pass is
// needed.
`default_nettype none

module feedback_echo_delay #(
    parameter int BUFFER_DEPTH = 131072,
    parameter int SAMPLE_BITS  = 24,
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [TDATA_W-1:0]             s_axis_tdata,  // in_sample
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [TDATA_W-1:0]             m_axis_tdata,  // out_sample
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fed_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [fed_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [fed_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    import fed_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
    localparam int MBW = LEVEL_W + 1;
    localparam int PW = SB + 1 + MBW;
    localparam int RW = SB + 3;
    localparam int SW = SB + 4;
    localparam longint SMAX_L = (64'sd1 <<< (SB - 1)) - 64'sd1;
    localparam longint SMIN_L = -SMAX_L - 64'sd1;
    localparam logic signed [SW-1:0] SMAX = SW'(SMAX_L);
    localparam logic signed [SW-1:0] SMIN = SW'(SMIN_L);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TONE,
        S_MIX,
        S_FDBK,
        S_WRITE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [DELAY_W-1:0] delay_length_reg;
    logic [GAIN_W-1:0]  feedback_gain_reg;
    logic [GAIN_W-1:0]  tone_coeff_reg;
    logic [LEVEL_W-1:0] mix_level_reg;
    logic               effect_en_reg;

    logic [AW-1:0]          write_index_reg, write_index_next;
    logic                   wrapped_reg, wrapped_next;
    logic                   mem_valid_reg, mem_valid_next;
    logic signed [SB-1:0]   dry_reg, dry_next;
    logic signed [SB-1:0]   delayed_reg, delayed_next;
    logic signed [SB-1:0]   damp_reg, damp_next;
    logic signed [SB-1:0]   res_reg, res_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [SB-1:0]   out_data_reg, out_data_next;

    logic                   in_accept;
    logic                   out_free;
    logic                   cfg_write;
    reg_index_t             cfg_index;

    logic [CW-1:0]          delay_ext, delay_lim, wi_ext, rd_full;
    logic [AW-1:0]          rd_addr;
    logic signed [SB-1:0]   mem_q;
    logic signed [SB-1:0]   delayed_now;
    logic signed [SB:0]     mul_a;
    logic signed [MBW-1:0]  mul_b;
    logic signed [PW-1:0]   prod_rnd;
    logic signed [RW-1:0]   rounded;
    logic signed [SB-1:0]   add_a;
    logic signed [SW-1:0]   acc_sum;
    logic signed [SB-1:0]   acc_sat;
    logic                   ram_we;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'($unsigned(out_data_reg));
    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite;
    assign cfg_index     = paddr[4:2];

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_DELAY_LENGTH:  prdata = APB_DATA_W'(delay_length_reg);
            REG_FEEDBACK_GAIN: prdata = APB_DATA_W'(feedback_gain_reg);
            REG_TONE_COEFF:    prdata = APB_DATA_W'(tone_coeff_reg);
            REG_MIX_LEVEL:     prdata = APB_DATA_W'(mix_level_reg);
            REG_EFFECT_EN:     prdata = APB_DATA_W'(effect_en_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        delay_ext = CW'(delay_length_reg);
        delay_lim = (delay_ext > CW'(BUFFER_DEPTH - 1)) ? CW'(BUFFER_DEPTH - 1) : delay_ext;
        wi_ext    = CW'(write_index_reg);
        rd_full   = (wi_ext >= delay_lim) ? (wi_ext - delay_lim)
                                          : (wi_ext + CW'(BUFFER_DEPTH) - delay_lim);
        rd_addr   = rd_full[AW-1:0];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_TONE:
            begin
                mul_a = (SB + 1)'(delayed_now) - (SB + 1)'(damp_reg);
                mul_b = $signed({2'b00, tone_coeff_reg});
            end
            S_MIX:
            begin
                mul_a = (SB + 1)'(delayed_reg);
                mul_b = $signed({1'b0, mix_level_reg});
            end
            S_FDBK:
            begin
                mul_a = (SB + 1)'(damp_reg);
                mul_b = $signed({2'b00, feedback_gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        delayed_now = mem_valid_reg ? mem_q : '0;
        prod_rnd    = prod_reg + PW'(ROUND_HALF);
        rounded     = RW'(prod_rnd >>> Q_FRAC);
        add_a       = (state_reg == S_MIX) ? damp_reg : dry_reg;
        acc_sum     = SW'(add_a) + SW'(rounded);
        if (acc_sum > SMAX)
        begin
            acc_sat = SB'(SMAX);
        end
        else if (acc_sum < SMIN)
        begin
            acc_sat = SB'(SMIN);
        end
        else
        begin
            acc_sat = SB'(acc_sum);
        end
    end

    assign ram_we = (state_reg == S_WRITE);

    always_comb
    begin
        state_next       = state_reg;
        write_index_next = write_index_reg;
        wrapped_next     = wrapped_reg;
        mem_valid_next   = mem_valid_reg;
        dry_next         = dry_reg;
        delayed_next     = delayed_reg;
        damp_next        = damp_reg;
        res_next         = res_reg;
        prod_next        = prod_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    dry_next = $signed(s_axis_tdata[SB-1:0]);
                    res_next = $signed(s_axis_tdata[SB-1:0]);
                    state_next = effect_en_reg ? S_READ : S_DONE;
                end
            end
            S_READ:
            begin
                mem_valid_next = wrapped_reg || (rd_addr < write_index_reg);
                state_next     = S_TONE;
            end
            S_TONE:
            begin
                delayed_next = delayed_now;
                prod_next    = mul_a * mul_b;
                state_next   = S_MIX;
            end
            S_MIX:
            begin
                damp_next  = SB'(acc_sum);
                prod_next  = mul_a * mul_b;
                state_next = S_FDBK;
            end
            S_FDBK:
            begin
                res_next   = acc_sat;
                prod_next  = mul_a * mul_b;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (write_index_reg == AW'(BUFFER_DEPTH - 1))
                begin
                    write_index_next = '0;
                    wrapped_next     = 1'b1;
                end
                else
                begin
                    write_index_next = write_index_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            delay_length_reg  <= DELAY_LENGTH_RST;
            feedback_gain_reg <= FEEDBACK_GAIN_RST;
            tone_coeff_reg    <= TONE_COEFF_RST;
            mix_level_reg     <= MIX_LEVEL_RST;
            effect_en_reg     <= 1'b1;
            write_index_reg   <= '0;
            wrapped_reg       <= 1'b0;
            mem_valid_reg     <= 1'b0;
            dry_reg           <= '0;
            delayed_reg       <= '0;
            damp_reg          <= '0;
            res_reg           <= '0;
            prod_reg          <= '0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            write_index_reg <= write_index_next;
            wrapped_reg     <= wrapped_next;
            mem_valid_reg   <= mem_valid_next;
            dry_reg         <= dry_next;
            delayed_reg     <= delayed_next;
            damp_reg        <= damp_next;
            res_reg         <= res_next;
            prod_reg        <= prod_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_DELAY_LENGTH:  delay_length_reg  <= pwdata[DELAY_W-1:0];
                    REG_FEEDBACK_GAIN: feedback_gain_reg <= pwdata[GAIN_W-1:0];
                    REG_TONE_COEFF:    tone_coeff_reg    <= pwdata[GAIN_W-1:0];
                    REG_MIX_LEVEL:     mix_level_reg     <= pwdata[LEVEL_W-1:0];
                    REG_EFFECT_EN:     effect_en_reg     <= pwdata[0];
                    default:           effect_en_reg     <= effect_en_reg;
                endcase
            end
        end
    end

    fed_ram #(
        .WIDTH(SB),
        .DEPTH(BUFFER_DEPTH)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (write_index_reg),
        .wr_data (acc_sat),
        .rd_addr (rd_addr),
        .rd_data (mem_q)
    );

    // The write index stays inside the buffer.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        write_index_reg <= AW'(BUFFER_DEPTH - 1))
        else $error("write index out of range");

    // The write index moves only on the memory write step.
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (write_index_reg != $past(write_index_reg)) |-> ($past(state_reg) == S_WRITE))
        else $error("write index moved outside the write step");

    // The filter state changes only on the filter update step.
    a_damp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (damp_reg != $past(damp_reg)) |-> ($past(state_reg) == S_MIX))
        else $error("filter state changed outside its update step");

    // A bypassed transaction leaves the delay memory untouched.
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !effect_en_reg) |=> (state_reg == S_DONE))
        else $error("bypassed sample entered the processing sequence");

    // A result is loaded into the output register only from the final step.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("output loaded outside the final step");

endmodule

`default_nettype wire
